[rtl/srpd_pkg.sv]
// shared constants, payload structs and control types of the sensor record decoder
package srpd_pkg;

    localparam int RECORDS      = 24;
    localparam int PORT_SLOTS   = 6;
    localparam int RECORD_BYTES = 3;
    localparam int BYTE_BITS    = 8;
    localparam int RECORD_AREA  = RECORDS * RECORD_BYTES;
    localparam int PAYLOAD_SIZE = RECORD_AREA + 2;

    localparam int BC_W   = $clog2(PAYLOAD_SIZE + 2);
    localparam int SLOT_W = $clog2(RECORDS);
    localparam int TGT_W  = $clog2(RECORDS + PORT_SLOTS);
    localparam int IDX_W  = 5;
    localparam int POS_W  = 3;
    localparam int TEMP_W = 16;
    localparam int STS_W  = 3;

    localparam logic [STS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STS_W-1:0] STS_LENGTH    = 3'd1;
    localparam logic [STS_W-1:0] STS_EMPTY_VAL = 3'd2;
    localparam logic [STS_W-1:0] STS_POSITION  = 3'd3;
    localparam logic [STS_W-1:0] STS_DUPLICATE = 3'd4;

    localparam logic [TEMP_W-1:0] MARKER_RESET = 16'h8000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         slot_index;
        logic [POS_W-1:0]         slot_position;
        logic signed [TEMP_W-1:0] slot_temperature;
        logic signed [TEMP_W-1:0] ambient_temperature;
        logic [STS_W-1:0]         status;
        logic                     run_end;
    } t_res;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_EMIT,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic take;
        logic emit_slot;
        logic emit_sum;
    } t_dp_cmd;

    typedef struct packed {
        logic good;
        logic emit_last;
    } t_dp_stat;

endpackage

[rtl/srpd_ctrl.sv]
// controller: byte intake, slot emission sweep and summary sequencing
module srpd_ctrl
    import srpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_last,
    input  t_dp_stat i_stat,
    output logic     busy,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RECV: begin
                if (start && i_last) begin
                    n_state = i_stat.good ? ST_EMIT : ST_SUM;
                end
            end
            ST_EMIT: begin
                if (i_stat.emit_last) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_RECV;
            end
            default: n_state = ST_RECV;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_RECV: begin
                busy       = 1'b0;
                o_cmd.take = start;
            end
            ST_EMIT: o_cmd.emit_slot = 1'b1;
            ST_SUM:  o_cmd.emit_sum  = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/srpd_dp.sv]
// datapath: record parsing, error latch, slot store, occupancy map and result register
module srpd_dp
    import srpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TEMP_W-1:0] i_cfg_wdata,
    input  t_req              i_req,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_valid,
    output t_res              o_res
);

    logic [TEMP_W-1:0] r_marker;
    logic [BC_W-1:0]   r_byte_cnt;
    logic [1:0]        r_phase;
    logic [2:0]        r_rec_in_port;
    logic [TGT_W-1:0]  r_port_base;
    logic [7:0]        r_held_pos;
    logic [7:0]        r_held_low;
    logic [STS_W-1:0]  r_first_err;
    logic [RECORDS-1:0] r_map;
    logic [TEMP_W-1:0] r_ambient;
    logic [STS_W-1:0]  r_sum_status;
    logic [TEMP_W-1:0] r_store [RECORDS];

    logic [SLOT_W-1:0] r_emit_cnt;
    logic [POS_W-1:0]  r_emit_pos;

    // read stage of the emission pipeline
    logic              r_p_slot;
    logic              r_p_sum;
    logic              r_p_taken;
    logic [SLOT_W-1:0] r_p_idx;
    logic [POS_W-1:0]  r_p_pos;
    logic [TEMP_W-1:0] r_rd_data;

    logic              r_out_valid;
    t_res              r_out;
    t_res              n_out;

    logic [TEMP_W-1:0] rec_temp;
    logic [TGT_W-1:0]  target;
    logic              tgt_in_range;
    logic              rec_byte;
    logic              rec_done;
    logic [STS_W-1:0]  n_err;
    logic              wr_slot;
    logic              pkt_len_ok;
    logic              clr;

    assign rec_temp     = {i_req.data_byte, r_held_low};
    assign target       = r_port_base + TGT_W'(r_held_pos[2:0]) - TGT_W'(1);
    assign tgt_in_range = target < TGT_W'(RECORDS);
    assign rec_byte     = r_byte_cnt < BC_W'(RECORD_AREA);
    assign rec_done     = i_cmd.take && rec_byte && (r_phase == 2'd2);
    assign pkt_len_ok   = r_byte_cnt == BC_W'(PAYLOAD_SIZE - 1);
    assign clr          = i_cmd.emit_sum;

    // record check, only while no earlier error is latched
    always_comb begin
        n_err   = r_first_err;
        wr_slot = 1'b0;
        if (rec_done && r_first_err == STS_OK) begin
            if (r_held_pos == 8'd0) begin
                if (rec_temp != r_marker) begin
                    n_err = STS_EMPTY_VAL;
                end
            end else if (r_held_pos > 8'(PORT_SLOTS)) begin
                n_err = STS_POSITION;
            end else if (!tgt_in_range) begin
                n_err = STS_POSITION;
            end else if (r_map[target[SLOT_W-1:0]]) begin
                n_err = STS_DUPLICATE;
            end else begin
                wr_slot = 1'b1;
            end
        end
    end

    assign o_stat.good      = pkt_len_ok && (r_first_err == STS_OK);
    assign o_stat.emit_last = r_emit_cnt == SLOT_W'(RECORDS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (i_cfg_we) begin
            r_marker <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt    <= '0;
            r_phase       <= '0;
            r_rec_in_port <= '0;
            r_port_base   <= '0;
            r_held_pos    <= '0;
            r_held_low    <= '0;
            r_first_err   <= STS_OK;
            r_map         <= '0;
        end else if (clr) begin
            r_byte_cnt    <= '0;
            r_phase       <= '0;
            r_rec_in_port <= '0;
            r_port_base   <= '0;
            r_held_pos    <= '0;
            r_held_low    <= '0;
            r_first_err   <= STS_OK;
            r_map         <= '0;
        end else if (i_cmd.take) begin
            r_first_err <= n_err;
            if (wr_slot) begin
                r_map[target[SLOT_W-1:0]] <= 1'b1;
            end
            if (rec_byte) begin
                case (r_phase)
                    2'd0: begin
                        r_held_pos <= i_req.data_byte;
                        r_phase    <= 2'd1;
                    end
                    2'd1: begin
                        r_held_low <= i_req.data_byte;
                        r_phase    <= 2'd2;
                    end
                    default: begin
                        r_phase <= 2'd0;
                        if (r_rec_in_port == 3'(PORT_SLOTS - 1)) begin
                            r_rec_in_port <= '0;
                            r_port_base   <= r_port_base + TGT_W'(PORT_SLOTS);
                        end else begin
                            r_rec_in_port <= r_rec_in_port + 3'd1;
                        end
                    end
                endcase
            end else if (r_byte_cnt == BC_W'(RECORD_AREA)) begin
                r_held_low <= i_req.data_byte;
            end
            if (r_byte_cnt < BC_W'(PAYLOAD_SIZE + 1)) begin
                r_byte_cnt <= r_byte_cnt + BC_W'(1);
            end
        end
    end

    // payload-only registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && r_byte_cnt == BC_W'(RECORD_AREA + 1)) begin
            r_ambient <= rec_temp;
        end
        if (i_cmd.take && i_req.last_byte) begin
            r_sum_status <= pkt_len_ok ? r_first_err : STS_LENGTH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_slot) begin
            r_store[target[SLOT_W-1:0]] <= rec_temp;
        end
        r_rd_data <= r_store[r_emit_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_cnt <= '0;
            r_emit_pos <= POS_W'(1);
            r_p_slot   <= 1'b0;
            r_p_sum    <= 1'b0;
        end else begin
            r_p_slot <= i_cmd.emit_slot;
            r_p_sum  <= i_cmd.emit_sum;
            if (clr) begin
                r_emit_cnt <= '0;
                r_emit_pos <= POS_W'(1);
            end else if (i_cmd.emit_slot) begin
                r_emit_cnt <= o_stat.emit_last ? '0 : r_emit_cnt + SLOT_W'(1);
                r_emit_pos <= (r_emit_pos == POS_W'(PORT_SLOTS)) ? POS_W'(1)
                                                                 : r_emit_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_taken <= r_map[r_emit_cnt];
        r_p_idx   <= r_emit_cnt;
        r_p_pos   <= r_emit_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_p_slot || r_p_sum;
        end
    end

    always_comb begin
        n_out = '0;
        if (r_p_sum) begin
            n_out.kind    = 1'b1;
            n_out.run_end = 1'b1;
            n_out.status  = r_sum_status;
            if (r_sum_status == STS_OK) begin
                n_out.ambient_temperature = r_ambient;
            end
        end else begin
            n_out.slot_index = IDX_W'(r_p_idx);
            if (r_p_taken) begin
                n_out.slot_position    = r_p_pos;
                n_out.slot_temperature = r_rd_data;
            end else begin
                n_out.slot_temperature = r_marker;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

[rtl/sensor_record_payload_decoder_unit.sv]
// top level of the sensor record payload decoder
// one byte request per cycle while busy is low; a request is taken when start is high
// a good packet ends with RECORDS slot results then a summary, one per cycle; busy stays
//   high through the emission sweep and the summary state
// a bad packet gives only its summary, busy high one cycle
// results are one-cycle strobes; the receiver cannot stall them
// synchronous active-low reset clears control state and the occupancy map; marker -32768
module sensor_record_payload_decoder_unit
    import srpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_req                     i_req,
    input  logic                     i_cfg_we,
    input  logic signed [TEMP_W-1:0] i_cfg_wdata,
    output logic                     o_valid,
    output t_res                     o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    srpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_req.last_byte),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    srpd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

endmodule

[tb/slot_result_checker.sv]
// checker for the sensor record decoder: tracks accepted bytes, predicts results, compares them
`timescale 1ns / 100ps

module slot_result_checker
    import srpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  t_req                     i_req,
    input  logic                     i_cfg_we,
    input  logic signed [TEMP_W-1:0] i_cfg_wdata,
    input  logic                     i_valid,
    input  t_res                     i_res,
    output int                       o_fail_count,
    output int                       o_pending
);

    logic signed [TEMP_W-1:0] marker;
    logic [BC_W-1:0]          byte_count;
    int                       rec_no;
    logic [1:0]               rec_phase;
    logic [7:0]               pos_hold;
    logic [7:0]               low_hold;
    logic [STS_W-1:0]         first_err;
    logic [RECORDS-1:0]       taken_map;
    logic signed [TEMP_W-1:0] slot_temp [RECORDS];
    logic signed [TEMP_W-1:0] ambient;
    t_res                     due_results [$];
    t_res                     oldest_due;

    function automatic string show_res(t_res r);
        return $sformatf("kind=%0d slot=%0d pos=%0d temp=%0d amb=%0d status=%0d end=%0d",
                         r.kind, r.slot_index, r.slot_position, r.slot_temperature,
                         r.ambient_temperature, r.status, r.run_end);
    endfunction

    task automatic clear_packet();
        byte_count = '0;
        rec_no     = 0;
        rec_phase  = '0;
        pos_hold   = '0;
        low_hold   = '0;
        first_err  = STS_OK;
        taken_map  = '0;
    endtask

    // only the first record error is latched
    task automatic check_record(input logic signed [TEMP_W-1:0] temp);
        int target;
        if (first_err == STS_OK) begin
            if (pos_hold == 0) begin
                if (temp != marker)
                    first_err = STS_EMPTY_VAL;
            end else if (pos_hold > PORT_SLOTS) begin
                first_err = STS_POSITION;
            end else begin
                target = (rec_no / PORT_SLOTS) * PORT_SLOTS + pos_hold - 1;
                if (target >= RECORDS) begin
                    first_err = STS_POSITION;
                end else if (taken_map[target]) begin
                    first_err = STS_DUPLICATE;
                end else begin
                    taken_map[target] = 1'b1;
                    slot_temp[target] = temp;
                end
            end
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (byte_count < RECORD_AREA) begin
            case (rec_phase)
                2'd0: begin
                    pos_hold  = b;
                    rec_phase = 2'd1;
                end
                2'd1: begin
                    low_hold  = b;
                    rec_phase = 2'd2;
                end
                default: begin
                    check_record({b, low_hold});
                    rec_phase = 2'd0;
                    rec_no++;
                end
            endcase
        end else if (byte_count == RECORD_AREA) begin
            low_hold = b;
        end else if (byte_count == RECORD_AREA + 1) begin
            ambient = {b, low_hold};
        end
        // bytes past the payload only push the count one beyond the size
        if (byte_count < PAYLOAD_SIZE + 1)
            byte_count++;
    endtask

    task automatic close_packet();
        t_res             r;
        logic [STS_W-1:0] sts;
        sts = (byte_count != PAYLOAD_SIZE) ? STS_LENGTH : first_err;
        if (sts == STS_OK) begin
            for (int i = 0; i < RECORDS; i++) begin
                r = '0;
                r.slot_index = IDX_W'(i);
                if (taken_map[i]) begin
                    r.slot_position    = POS_W'(i % PORT_SLOTS + 1);
                    r.slot_temperature = slot_temp[i];
                end else begin
                    r.slot_temperature = marker;
                end
                due_results.push_back(r);
            end
            r = '0;
            r.kind                = 1'b1;
            r.ambient_temperature = ambient;
            r.run_end             = 1'b1;
        end else begin
            r = '0;
            r.kind    = 1'b1;
            r.status  = sts;
            r.run_end = 1'b1;
        end
        due_results.push_back(r);
        clear_packet();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            marker = MARKER_RESET;
            clear_packet();
            due_results.delete();
        end else begin
            if (i_valid) begin
                if (due_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, actual %s",
                             $time, show_res(i_res));
                end else begin
                    oldest_due = due_results.pop_front();
                    if (i_res !== oldest_due) begin
                        o_fail_count++;
                        $display("%0t: result mismatch, expected %s, actual %s",
                                 $time, show_res(oldest_due), show_res(i_res));
                    end
                end
            end
            if (i_cfg_we)
                marker = i_cfg_wdata;
            if (i_start && !i_busy) begin
                absorb_byte(i_req.data_byte);
                if (i_req.last_byte)
                    close_packet();
            end
        end
        o_pending = due_results.size();
    end

endmodule

[tb/testbench.sv]
// top of the sensor record decoder testbench: clock, reset, packet stimulus and verdict
`timescale 1ns / 100ps

module testbench;
    import srpd_pkg::*;

    typedef enum int {
        PK_GOOD,
        PK_EMPTY_VAL,
        PK_OVER6,
        PK_DUP,
        PK_SHORT,
        PK_LONG,
        PK_NOISE
    } t_pkt_kind;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    t_req                     i_req       = '0;
    logic                     i_cfg_we    = 1'b0;
    logic signed [TEMP_W-1:0] i_cfg_wdata = '0;
    logic                     o_valid;
    t_res                     o_res;
    int                       fail_count;
    int                       pending;

    logic [7:0]               pkt_bytes [$];
    logic [7:0]               rec_pos  [RECORDS];
    logic [TEMP_W-1:0]        rec_temp [RECORDS];
    logic signed [TEMP_W-1:0] cur_marker = MARKER_RESET;
    int                       idle_pct   = 0;

    sensor_record_payload_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

    slot_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [TEMP_W-1:0] pick_temp();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return TEMP_W'($urandom);
        endcase
    endfunction

    // one request per byte, start held high across back-to-back bytes
    task automatic send_packet();
        int gap;
        foreach (pkt_bytes[k]) begin
            gap = 0;
            while (idle_pct > 0 && $urandom_range(99) < idle_pct)
                gap++;
            @(negedge i_clk);
            repeat (gap) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
            start <= 1'b1;
            i_req <= {pkt_bytes[k], k == pkt_bytes.size() - 1};
            @(posedge i_clk);
            while (busy)
                @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_marker(input logic signed [TEMP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_marker = value;
    endtask

    task automatic build_packet(input t_pkt_kind kind);
        int        fill;
        int        r;
        int        k;
        int        a;
        int        b;
        int        n_err;
        t_pkt_kind err;
        logic [PORT_SLOTS-1:0] used;
        logic [TEMP_W-1:0]     amb;
        pkt_bytes.delete();
        // all empty, all taken, or a random mix
        fill = $urandom_range(2);
        for (int p = 0; p < RECORDS / PORT_SLOTS; p++) begin
            used = '0;
            for (int j = 0; j < PORT_SLOTS; j++) begin
                r = p * PORT_SLOTS + j;
                if (fill == 1 || (fill == 2 && $urandom_range(1) == 1)) begin
                    k = $urandom_range(PORT_SLOTS - 1);
                    while (used[k])
                        k = (k + 1) % PORT_SLOTS;
                    used[k]     = 1'b1;
                    rec_pos[r]  = 8'(k + 1);
                    rec_temp[r] = pick_temp();
                end else begin
                    rec_pos[r]  = 8'd0;
                    rec_temp[r] = cur_marker;
                end
            end
        end
        if (kind == PK_EMPTY_VAL || kind == PK_OVER6 || kind == PK_DUP) begin
            err   = kind;
            n_err = ($urandom_range(3) == 0) ? 2 : 1;
        end else begin
            err   = t_pkt_kind'($urandom_range(PK_EMPTY_VAL, PK_DUP));
            n_err = (kind == PK_SHORT || kind == PK_LONG) ? $urandom_range(1) : 0;
        end
        for (int e = 0; e < n_err; e++) begin
            r = $urandom_range(RECORDS - 1);
            case (err)
                PK_EMPTY_VAL: begin
                    rec_pos[r]  = 8'd0;
                    rec_temp[r] = cur_marker ^ TEMP_W'($urandom_range(1, 65535));
                end
                PK_OVER6: begin
                    rec_pos[r] = 8'($urandom_range(PORT_SLOTS + 1, 255));
                end
                default: begin
                    // two records of one port naming the same position
                    a = $urandom_range(RECORDS / PORT_SLOTS - 1) * PORT_SLOTS
                        + $urandom_range(PORT_SLOTS - 2);
                    b = a + 1 + $urandom_range(PORT_SLOTS - 2 - a % PORT_SLOTS);
                    k = $urandom_range(1, PORT_SLOTS);
                    rec_pos[a] = 8'(k);
                    rec_pos[b] = 8'(k);
                end
            endcase
            err = t_pkt_kind'($urandom_range(PK_EMPTY_VAL, PK_DUP));
        end
        for (int i = 0; i < RECORDS; i++) begin
            pkt_bytes.push_back(rec_pos[i]);
            pkt_bytes.push_back(rec_temp[i][7:0]);
            pkt_bytes.push_back(rec_temp[i][15:8]);
        end
        amb = pick_temp();
        pkt_bytes.push_back(amb[7:0]);
        pkt_bytes.push_back(amb[15:8]);
        case (kind)
            PK_SHORT: begin
                k = $urandom_range(1, PAYLOAD_SIZE - 1);
                while (pkt_bytes.size() > k)
                    void'(pkt_bytes.pop_back());
            end
            PK_LONG: begin
                repeat ($urandom_range(1, 6))
                    pkt_bytes.push_back(8'($urandom));
            end
            PK_NOISE: begin
                pkt_bytes.delete();
                repeat ($urandom_range(1, PAYLOAD_SIZE + 4))
                    pkt_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    initial begin
        int        ph_bytes;
        int        ph_pkts;
        int        pkt_no;
        int        pick;
        t_pkt_kind kind;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short packets under the reset marker, length error always wins
        pkt_bytes = '{8'hFF};
        send_packet();
        pkt_bytes = '{8'h00, 8'h00, 8'h80, 8'h00};
        send_packet();
        pkt_bytes = '{8'h07, 8'h34, 8'h12, 8'h5A};
        send_packet();
        pkt_bytes = '{8'h00, 8'hFF, 8'h7F, 8'hA5};
        send_packet();
        pkt_bytes = '{8'h01, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h55};
        send_packet();
        pkt_bytes = '{8'h06, 8'h01, 8'h80, 8'hFF, 8'hFE};
        send_packet();
        wait_drained();

        pkt_no = 0;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_marker(16'sh7FFF);
                    idle_pct = 24;
                end
                1: begin
                    write_marker(16'sh8000);
                    idle_pct = 62;
                end
                default: begin
                    write_marker(TEMP_W'($urandom));
                    idle_pct = 0;
                end
            endcase
            ph_bytes = 0;
            ph_pkts  = 0;
            while (ph_bytes < 60 && ph_pkts < 2) begin
                if (pkt_no <= PK_NOISE) begin
                    kind = t_pkt_kind'(pkt_no);
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 40)      kind = PK_GOOD;
                    else if (pick < 50) kind = PK_EMPTY_VAL;
                    else if (pick < 60) kind = PK_OVER6;
                    else if (pick < 70) kind = PK_DUP;
                    else if (pick < 80) kind = PK_SHORT;
                    else if (pick < 90) kind = PK_LONG;
                    else                kind = PK_NOISE;
                end
                build_packet(kind);
                ph_bytes += pkt_bytes.size();
                ph_pkts++;
                pkt_no++;
                send_packet();
                // now and then hold off until the decoder has emptied out
                if ($urandom_range(3) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
